// File: src/rv64i_execute_unit_top_macros.svh
// Assertion macros shared by the execute unit checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RV64I_EXECUTE_UNIT_TOP_MACROS_SVH
`define RV64I_EXECUTE_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define RVEX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define RVEX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: src/rvex_pkg.sv
// Types, operation codes and helpers for the RV64I execute unit.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package rvex_pkg;

  typedef enum logic [5:0] {
    OP_LUI    = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
    OP_BEQ    = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BLTU  = 6'd7,
    OP_BGE    = 6'd8,  OP_BGEU  = 6'd9,  OP_LB    = 6'd10, OP_LBU   = 6'd11,
    OP_LH     = 6'd12, OP_LHU   = 6'd13, OP_LW    = 6'd14, OP_LWU   = 6'd15,
    OP_LD     = 6'd16, OP_SB    = 6'd17, OP_SH    = 6'd18, OP_SW    = 6'd19,
    OP_SD     = 6'd20, OP_ADD   = 6'd21, OP_ADDI  = 6'd22, OP_ADDW  = 6'd23,
    OP_ADDIW  = 6'd24, OP_SLT   = 6'd25, OP_SLTI  = 6'd26, OP_SLTU  = 6'd27,
    OP_SLTIU  = 6'd28, OP_SLL   = 6'd29, OP_SLLI  = 6'd30, OP_SLLW  = 6'd31,
    OP_SLLIW  = 6'd32, OP_SRL   = 6'd33, OP_SRLI  = 6'd34, OP_SRLW  = 6'd35,
    OP_SRLIW  = 6'd36, OP_SRA   = 6'd37, OP_SRAI  = 6'd38, OP_SRAW  = 6'd39,
    OP_SRAIW  = 6'd40, OP_XOR   = 6'd41, OP_OR    = 6'd42, OP_AND   = 6'd43,
    OP_XORI   = 6'd44, OP_ORI   = 6'd45, OP_ANDI  = 6'd46, OP_SUB   = 6'd47,
    OP_SUBW   = 6'd48, OP_ECALL = 6'd49, OP_EBREAK = 6'd50
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_HALF  = 2'd1,
    SZ_WORD  = 2'd2,
    SZ_DWORD = 2'd3
  } mem_size_e;

  typedef struct packed {
    logic [5:0]         op;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic [2:0]         instr_len;
  } exec_req_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic        branch_taken;
    logic        reg_write_en;
    logic [4:0]  reg_write_idx;
    logic [63:0] reg_write_value;
    logic        status;
  } exec_rsp_t;

  function automatic logic [63:0] sext32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic logic misaligned(input mem_size_e sz, input logic [2:0] lo);
    logic bad;
    unique case (sz)
      SZ_BYTE:  bad = 1'b0;
      SZ_HALF:  bad = lo[0];
      SZ_WORD:  bad = |lo[1:0];
      SZ_DWORD: bad = |lo;
      default:  bad = 1'b0;
    endcase
    return bad;
  endfunction

  function automatic logic [7:0] byte_mask(input mem_size_e sz);
    logic [7:0] m;
    unique case (sz)
      SZ_BYTE:  m = 8'h01;
      SZ_HALF:  m = 8'h03;
      SZ_WORD:  m = 8'h0f;
      SZ_DWORD: m = 8'hff;
      default:  m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/rv64i_execute_unit_top.sv
// RV64I execute unit: register file, PC, data memory and a three-stage pipe.
// Depends on rvex_pkg.
`default_nettype none

// Channel | Signals                            | Moves
// --------+------------------------------------+------------------------------
// in      | in_valid_i, in_stall_o, in_req_i   | one decoded instruction
// out     | out_valid_o, out_stall_i, out_rsp_o| one execute result
//
// One instruction per cycle sustained while the output is not stalled.
// A result passes operand read, execute with memory access and load align
// into the output register, in that order. After reset the data memory is
// cleared one 8-byte row a cycle; no request is taken until the clear is done.
// MEM_BYTES must be a power of two; the block itself does not enforce it.
// Stalls on the output back up stage by stage; bubbles are filled first.

module rv64i_execute_unit_top import rvex_pkg::*; #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire exec_req_t in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output exec_rsp_t      out_rsp_o
);

  localparam int unsigned ROWS  = MEM_BYTES / 8;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // storage
  logic [63:0] rf_q [32];
  logic [31:0] rf_vld_q;
  logic [63:0] mem_q [ROWS];
  logic [63:0] mem_rdata_q;
  logic [63:0] pc_q;

  logic             clr_busy_q;
  logic [ROW_W-1:0] clr_idx_q;

  // X stage
  logic        x_valid_q;
  exec_req_t   x_req_q;
  logic [63:0] x_a_q, x_b_q;

  // M stage
  logic        m_valid_q, m_wr_q, m_ld_q, m_ld_sgn_q, m_taken_q, m_bad_q;
  logic [4:0]  m_rd_q;
  logic [63:0] m_val_q, m_npc_q;
  mem_size_e   m_ld_size_q;
  logic [2:0]  m_off_q;

  // output register
  logic        out_valid_q;
  exec_rsp_t   out_rsp_q;

  logic o_free, m_adv, m_free, x_adv, x_free, in_acc, rf_we;
  logic [63:0] m_res;

  assign o_free     = !out_valid_q || !out_stall_i;
  assign m_adv      = m_valid_q && o_free;
  assign m_free     = !m_valid_q || m_adv;
  assign x_adv      = x_valid_q && m_free;
  assign x_free     = !x_valid_q || x_adv;
  assign in_stall_o = !x_free || clr_busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rf_we      = m_adv && m_wr_q;

  // load align and extend
  logic [63:0] ld_sh;
  assign ld_sh = mem_rdata_q >> {m_off_q, 3'b000};

  always_comb begin
    unique case (m_ld_size_q)
      SZ_BYTE:  m_res = {{56{m_ld_sgn_q & ld_sh[7]}}, ld_sh[7:0]};
      SZ_HALF:  m_res = {{48{m_ld_sgn_q & ld_sh[15]}}, ld_sh[15:0]};
      SZ_WORD:  m_res = {{32{m_ld_sgn_q & ld_sh[31]}}, ld_sh[31:0]};
      SZ_DWORD: m_res = ld_sh;
      default:  m_res = ld_sh;
    endcase
    if (!m_ld_q) begin
      m_res = m_val_q;
    end
  end

  // operands with bypass from the instruction one stage ahead
  logic [63:0] fa, fb, imm64, ea;
  assign fa = (m_valid_q && m_wr_q && m_rd_q == x_req_q.src_reg_a) ? m_res : x_a_q;
  assign fb = (m_valid_q && m_wr_q && m_rd_q == x_req_q.src_reg_b) ? m_res : x_b_q;
  assign imm64 = {{32{x_req_q.immediate[31]}}, x_req_q.immediate};
  assign ea = fa + imm64;

  logic [63:0] x_val, x_npc, x_link;
  logic        x_wr, x_taken, x_cond, x_bad, x_ld, x_ld_sgn, x_st;
  mem_size_e   x_size;
  logic [31:0] sraw_res;
  logic [4:0]  sh5;
  logic [7:0]  st_be;
  logic [63:0] st_data;
  logic [ROW_W-1:0] mem_row;

  assign x_link  = pc_q + {61'd0, x_req_q.instr_len};
  assign mem_row = ea[ROW_W+2:3];
  assign st_be   = byte_mask(x_size) << ea[2:0];
  assign st_data = fb << {ea[2:0], 3'b000};

  always_comb begin
    x_val    = '0;
    x_wr     = 1'b0;
    x_cond   = 1'b0;
    x_taken  = 1'b0;
    x_npc    = x_link;
    x_ld     = 1'b0;
    x_ld_sgn = 1'b0;
    x_st     = 1'b0;
    x_size   = SZ_BYTE;
    sh5      = fb[4:0];
    sraw_res = '0;
    unique case (op_e'(x_req_q.op))
      OP_LUI:   begin x_val = imm64; x_wr = 1'b1; end
      OP_AUIPC: begin x_val = pc_q + imm64; x_wr = 1'b1; end
      OP_JAL: begin
        x_val = x_link; x_wr = 1'b1; x_npc = pc_q + imm64; x_taken = 1'b1;
      end
      OP_JALR: begin
        x_val = x_link; x_wr = 1'b1; x_npc = {ea[63:1], 1'b0}; x_taken = 1'b1;
      end
      OP_BEQ:  x_cond = (fa == fb);
      OP_BNE:  x_cond = (fa != fb);
      OP_BLT:  x_cond = ($signed(fa) < $signed(fb));
      OP_BLTU: x_cond = (fa < fb);
      OP_BGE:  x_cond = !($signed(fa) < $signed(fb));
      OP_BGEU: x_cond = (fa >= fb);
      OP_LB:  begin x_ld = 1'b1; x_ld_sgn = 1'b1; x_size = SZ_BYTE;  end
      OP_LBU: begin x_ld = 1'b1;                  x_size = SZ_BYTE;  end
      OP_LH:  begin x_ld = 1'b1; x_ld_sgn = 1'b1; x_size = SZ_HALF;  end
      OP_LHU: begin x_ld = 1'b1;                  x_size = SZ_HALF;  end
      OP_LW:  begin x_ld = 1'b1; x_ld_sgn = 1'b1; x_size = SZ_WORD;  end
      OP_LWU: begin x_ld = 1'b1;                  x_size = SZ_WORD;  end
      OP_LD:  begin x_ld = 1'b1;                  x_size = SZ_DWORD; end
      OP_SB:  begin x_st = 1'b1; x_size = SZ_BYTE;  end
      OP_SH:  begin x_st = 1'b1; x_size = SZ_HALF;  end
      OP_SW:  begin x_st = 1'b1; x_size = SZ_WORD;  end
      OP_SD:  begin x_st = 1'b1; x_size = SZ_DWORD; end
      OP_ADD:   begin x_val = fa + fb; x_wr = 1'b1; end
      OP_ADDI:  begin x_val = ea; x_wr = 1'b1; end
      OP_ADDW:  begin x_val = sext32(fa + fb); x_wr = 1'b1; end
      OP_ADDIW: begin x_val = sext32(ea); x_wr = 1'b1; end
      OP_SLT:   begin x_val = {63'd0, $signed(fa) < $signed(fb)}; x_wr = 1'b1; end
      OP_SLTI:  begin x_val = {63'd0, $signed(fa) < $signed(imm64)}; x_wr = 1'b1; end
      OP_SLTU:  begin x_val = {63'd0, fa < fb}; x_wr = 1'b1; end
      OP_SLTIU: begin x_val = {63'd0, fa < imm64}; x_wr = 1'b1; end
      OP_SLL:   begin x_val = fa << fb[5:0]; x_wr = 1'b1; end
      OP_SLLI:  begin x_val = fa << imm64[5:0]; x_wr = 1'b1; end
      OP_SLLW:  begin x_val = sext32(fa << fb[4:0]); x_wr = 1'b1; end
      OP_SLLIW: begin x_val = sext32(fa << imm64[4:0]); x_wr = 1'b1; end
      OP_SRL:   begin x_val = fa >> fb[5:0]; x_wr = 1'b1; end
      OP_SRLI:  begin x_val = fa >> imm64[5:0]; x_wr = 1'b1; end
      OP_SRLW:  begin x_val = sext32({32'd0, fa[31:0]} >> fb[4:0]); x_wr = 1'b1; end
      OP_SRLIW: begin x_val = sext32({32'd0, fa[31:0]} >> imm64[4:0]); x_wr = 1'b1; end
      OP_SRA:   begin x_val = $unsigned($signed(fa) >>> fb[5:0]); x_wr = 1'b1; end
      OP_SRAI:  begin x_val = $unsigned($signed(fa) >>> imm64[5:0]); x_wr = 1'b1; end
      OP_SRAW, OP_SRAIW: begin
        sh5 = (op_e'(x_req_q.op) == OP_SRAIW) ? imm64[4:0] : fb[4:0];
        sraw_res = $unsigned($signed(fa[31:0]) >>> sh5);
        x_val = {{32{sraw_res[31]}}, sraw_res};
        x_wr = 1'b1;
      end
      OP_XOR:  begin x_val = fa ^ fb; x_wr = 1'b1; end
      OP_OR:   begin x_val = fa | fb; x_wr = 1'b1; end
      OP_AND:  begin x_val = fa & fb; x_wr = 1'b1; end
      OP_XORI: begin x_val = fa ^ imm64; x_wr = 1'b1; end
      OP_ORI:  begin x_val = fa | imm64; x_wr = 1'b1; end
      OP_ANDI: begin x_val = fa & imm64; x_wr = 1'b1; end
      OP_SUB:  begin x_val = fa - fb; x_wr = 1'b1; end
      OP_SUBW: begin x_val = sext32(fa - fb); x_wr = 1'b1; end
      default: ;
    endcase
    x_bad = (x_ld || x_st) && misaligned(x_size, ea[2:0]);
    if (x_ld && !x_bad) begin
      x_wr = 1'b1;
    end
    if (x_cond) begin
      x_npc   = pc_q + imm64;
      x_taken = 1'b1;
    end
    // x0 is never written
    if (x_req_q.dest_reg == 5'd0) begin
      x_wr = 1'b0;
    end
    if (!x_wr) begin
      x_val = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      pc_q        <= '0;
      rf_vld_q    <= '0;
      x_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_ROW) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (x_adv) begin
        pc_q <= x_npc;
      end
      if (rf_we) begin
        rf_vld_q[m_rd_q] <= 1'b1;
      end
      if (x_free) begin
        x_valid_q <= in_acc;
      end
      if (m_free) begin
        m_valid_q <= x_adv;
      end
      if (o_free) begin
        out_valid_q <= m_adv;
      end
    end
  end

  // register file; operand snapshots follow writes while the request waits
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[m_rd_q] <= m_res;
    end
    if (in_acc) begin
      x_req_q <= in_req_i;
      if (rf_we && m_rd_q == in_req_i.src_reg_a) begin
        x_a_q <= m_res;
      end else begin
        x_a_q <= rf_vld_q[in_req_i.src_reg_a] ? rf_q[in_req_i.src_reg_a] : '0;
      end
      if (rf_we && m_rd_q == in_req_i.src_reg_b) begin
        x_b_q <= m_res;
      end else begin
        x_b_q <= rf_vld_q[in_req_i.src_reg_b] ? rf_q[in_req_i.src_reg_b] : '0;
      end
    end else if (rf_we) begin
      if (m_rd_q == x_req_q.src_reg_a) begin
        x_a_q <= m_res;
      end
      if (m_rd_q == x_req_q.src_reg_b) begin
        x_b_q <= m_res;
      end
    end
  end

  // data memory, one access per cycle
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (x_adv && x_st && !x_bad) begin
      for (int i = 0; i < 8; i++) begin
        if (st_be[i]) begin
          mem_q[mem_row][i*8 +: 8] <= st_data[i*8 +: 8];
        end
      end
    end
    if (x_adv && x_ld && !x_bad) begin
      mem_rdata_q <= mem_q[mem_row];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (x_adv) begin
      m_wr_q      <= x_wr;
      m_rd_q      <= x_req_q.dest_reg;
      m_val_q     <= x_val;
      m_npc_q     <= x_npc;
      m_taken_q   <= x_taken;
      m_bad_q     <= x_bad;
      m_ld_q      <= x_ld && !x_bad;
      m_ld_sgn_q  <= x_ld_sgn;
      m_ld_size_q <= x_size;
      m_off_q     <= ea[2:0];
    end
    if (m_adv) begin
      out_rsp_q.next_pc         <= m_npc_q;
      out_rsp_q.branch_taken    <= m_taken_q;
      out_rsp_q.reg_write_en    <= m_wr_q;
      out_rsp_q.reg_write_idx   <= m_wr_q ? m_rd_q : 5'd0;
      out_rsp_q.reg_write_value <= m_wr_q ? m_res : 64'd0;
      out_rsp_q.status          <= m_bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// File: src/rvex_checker.sv
// Port-level checks for the RV64I execute unit, bound to the top level.
// Depends on rvex_pkg and rv64i_execute_unit_top_macros.svh.
`default_nettype none
`include "rv64i_execute_unit_top_macros.svh"

module rvex_checker import rvex_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire exec_req_t in_req_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire exec_rsp_t out_rsp_o
);

  // a result without a write carries a clean index and value
  `RVEX_ASSERT_IMP(a_nowr_clean, out_valid_o && !out_rsp_o.reg_write_en, out_rsp_o.reg_write_idx == 5'd0 && out_rsp_o.reg_write_value == 64'd0)
  // x0 is never reported as written
  `RVEX_ASSERT_IMP(a_wr_nonzero, out_valid_o && out_rsp_o.reg_write_en, out_rsp_o.reg_write_idx != 5'd0)
  // a suppressed access neither writes nor redirects
  `RVEX_ASSERT_IMP(a_bad_quiet, out_valid_o && out_rsp_o.status, !out_rsp_o.reg_write_en && !out_rsp_o.branch_taken)
  // a stalled result holds
  `RVEX_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))
  // a stalled request holds
  `RVEX_ASSERT_NXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_req_i))

endmodule

bind rv64i_execute_unit_top rvex_checker u_rvex_checker (.*);

`default_nettype wire
